FILE: hw/rtl/fcou_pkg.sv
// Package for the fly camera orientation update block.
// Holds the fixed-point constants, codes, the arctangent table and rounding helpers.
// Used by fcou_cordic and the top level (fcou_mul does not import it); depends on nothing.
`default_nettype none
package fcou_pkg;

  localparam int unsigned TrigStepsDefault = 16;
  localparam int unsigned MaxSteps         = 24;

  localparam logic [35:0]        FullTurn   = 36'd23592960;
  localparam logic signed [25:0] HalfTurn   = 26'sd11796480;
  localparam logic signed [25:0] Quarter    = 26'sd5898240;
  localparam logic signed [34:0] PitchLimit = 35'sd5832704;
  localparam logic [24:0]        YawHome    = 25'd17694720;
  localparam logic [35:0]        YawBias    = 36'd3019898880;
  localparam logic signed [32:0] CordicK30  = 33'sd652032874;
  localparam logic signed [15:0] One14      = 16'sd16384;
  localparam logic [15:0]        SpeedReset = 16'd1280;
  localparam logic [15:0]        SensReset  = 16'd6554;

  typedef enum logic [1:0] {
    KIND_MOVE = 2'd0,
    KIND_LOOK = 2'd1,
    KIND_HOME = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    DIR_FWD   = 3'd0,
    DIR_BACK  = 3'd1,
    DIR_LEFT  = 3'd2,
    DIR_RIGHT = 3'd3,
    DIR_UP    = 3'd4,
    DIR_DOWN  = 3'd5
  } dir_e;

  typedef enum logic [2:0] {
    REG_SPEED  = 3'd0,
    REG_SENS   = 3'd1,
    REG_HOME_X = 3'd2,
    REG_HOME_Y = 3'd3,
    REG_HOME_Z = 3'd4
  } reg_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_LOOK_X, ST_LOOK_Y, ST_LOOK_P, ST_YAW_MOD,
    ST_CORD_Y, ST_WAIT_Y, ST_CORD_P, ST_WAIT_P,
    ST_BASIS0, ST_BASIS1, ST_BASIS2, ST_BASIS3, ST_BASIS4,
    ST_MOVE_VEL, ST_MOVE_CAP, ST_MOVE_X, ST_MOVE_Y, ST_MOVE_Z, ST_MOVE_END,
    ST_OUT
  } state_e;

  function automatic logic [21:0] atan_deg16(input logic [4:0] idx);
    logic [21:0] r;
    case (idx)
      5'd0:  r = 22'd2949120;
      5'd1:  r = 22'd1740967;
      5'd2:  r = 22'd919879;
      5'd3:  r = 22'd466945;
      5'd4:  r = 22'd234379;
      5'd5:  r = 22'd117304;
      5'd6:  r = 22'd58666;
      5'd7:  r = 22'd29335;
      5'd8:  r = 22'd14668;
      5'd9:  r = 22'd7334;
      5'd10: r = 22'd3667;
      5'd11: r = 22'd1833;
      5'd12: r = 22'd917;
      5'd13: r = 22'd458;
      5'd14: r = 22'd229;
      5'd15: r = 22'd115;
      5'd16: r = 22'd57;
      5'd17: r = 22'd29;
      5'd18: r = 22'd14;
      5'd19: r = 22'd7;
      5'd20: r = 22'd4;
      5'd21: r = 22'd2;
      5'd22: r = 22'd1;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

  // Rounds to nearest (ties up) by the given shift and clamps to [-1, 1] in Q1.14.
  function automatic logic signed [15:0] round_q14(input logic signed [65:0] v,
                                                   input int unsigned sh);
    logic signed [65:0] t;
    logic signed [15:0] r;
    t = (v + (66'sd1 <<< (sh - 1))) >>> sh;
    if (t > 66'sd16384) begin
      r = One14;
    end else if (t < -66'sd16384) begin
      r = -One14;
    end else begin
      r = t[15:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/fcou_mul.sv
// Shared signed 33 x 33 multiplier with a registered product.
// Depends on nothing; used by the top level for every product of the block.
`default_nettype none
module fcou_mul (
  input  wire logic               clk_i,
  input  wire logic signed [32:0] a_i,
  input  wire logic signed [32:0] b_i,
  output logic signed [65:0]      p_o
);

  logic signed [65:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule
`default_nettype wire

FILE: hw/rtl/fcou_cordic.sv
// Iterative rotation-mode CORDIC giving cosine and sine in Q1.30 of an angle in Q16 degrees.
// Depends on fcou_pkg for the arctangent table and constants.
`default_nettype none
module fcou_cordic import fcou_pkg::*; #(
  parameter int unsigned TRIG_STEPS = TrigStepsDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [25:0] angle_i,
  output logic                    done_o,
  output logic signed [31:0]      cos_o,
  output logic signed [31:0]      sin_o
);

  localparam int unsigned NSteps = (TRIG_STEPS > MaxSteps) ? MaxSteps : TRIG_STEPS;

  logic               busy_q, done_q, neg_q;
  logic [4:0]         cnt_q;
  logic signed [32:0] x_q, y_q, x_d, y_d, dx, dy;
  logic signed [26:0] z_q, z_d, az, ang_fold;
  logic               neg_d;
  logic signed [32:0] cos_w, sin_w;

  always_comb begin
    neg_d    = 1'b0;
    ang_fold = 27'(angle_i);
    if (angle_i > Quarter) begin
      ang_fold = 27'(angle_i) - 27'(HalfTurn);
      neg_d    = 1'b1;
    end else if (angle_i < -Quarter) begin
      ang_fold = 27'(angle_i) + 27'(HalfTurn);
      neg_d    = 1'b1;
    end
    dx = y_q >>> cnt_q;
    dy = x_q >>> cnt_q;
    az = 27'(signed'({1'b0, atan_deg16(cnt_q)}));
    if (z_q >= 27'sd0) begin
      x_d = x_q - dx;
      y_d = y_q + dy;
      z_d = z_q - az;
    end else begin
      x_d = x_q + dx;
      y_d = y_q - dy;
      z_d = z_q + az;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'(NSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= CordicK30;
      y_q   <= '0;
      z_q   <= ang_fold;
      neg_q <= neg_d;
    end else if (busy_q) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign cos_w  = neg_q ? -x_q : x_q;
  assign sin_w  = neg_q ? -y_q : y_q;
  assign cos_o  = cos_w[31:0];
  assign sin_o  = sin_w[31:0];
  assign done_o = done_q;

endmodule
`default_nettype wire

FILE: hw/rtl/fly_camera_orientation_update_top.sv
// Fly camera orientation update, top level: stream ports, APB registers and the sequencer.
// Depends on fcou_pkg, fcou_mul and fcou_cordic.
//
// One item is taken at a time and gives one result item, the camera state after the update.
// A look item runs two passes of the shared CORDIC unit and six products through the single
// shared multiplier; a move item uses the multiplier alone, and a restart, an idle kind or a
// move with an invalid direction goes straight to the result. The result stays
// on the output until it is taken, and the next item is accepted in the cycle after that.
`default_nettype none
module fly_camera_orientation_update_top import fcou_pkg::*; #(
  parameter int unsigned TRIG_STEPS = TrigStepsDefault
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_tvalid_i,
  output logic              s_tready_o,
  // direction[2:0], delta_time[18:3], x_offset[42:19], y_offset[66:43], zero fill
  input  wire logic [71:0]  s_tdata_i,
  // kind[1:0]
  input  wire logic [1:0]   s_tuser_i,
  output logic              m_tvalid_o,
  input  wire logic         m_tready_i,
  // pos_x, pos_y, pos_z (32 bits each), then front_x/y/z, right_x/y/z, up_x/y/z (16 each)
  output logic [239:0]      m_tdata_o,
  input  wire logic         psel_i,
  input  wire logic         penable_i,
  input  wire logic         pwrite_i,
  input  wire logic [4:0]   paddr_i,
  input  wire logic [31:0]  pwdata_i,
  output logic [31:0]       prdata_o,
  output logic              pready_o
);

  state_e state_q, state_d;

  logic [15:0]        speed_q, sens_q;
  logic signed [31:0] home_q [3];
  logic signed [31:0] pos_q  [3];
  logic [24:0]        yaw_q;
  logic signed [23:0] pitch_q;
  logic signed [15:0] front_q [3];
  logic signed [15:0] right_x_q, right_z_q;
  logic signed [15:0] up_q [3];

  logic [2:0]         dir_q;
  logic [15:0]        dt_q;
  logic signed [23:0] xo_q, yo_q;
  logic [35:0]        ys_q;
  logic [2:0]         cnt_q;
  logic [31:0]        vel_q;
  logic signed [31:0] cy_q, sy_q, cp_q, sp_q;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic               cord_start, cord_done;
  logic signed [25:0] cord_angle;
  logic signed [31:0] cord_cos, cord_sin;

  logic               s_acc, cfg_wr;
  logic signed [65:0] rnd8;
  logic signed [33:0] dmove;
  logic [35:0]        ys_step;
  logic signed [34:0] pitch_sum;
  logic signed [16:0] comp [3];

  assign pready_o   = 1'b1;
  assign cfg_wr     = psel_i && penable_i && pwrite_i;
  assign s_tready_o = (state_q == ST_IDLE);
  assign s_acc      = s_tvalid_i && s_tready_o;
  assign m_tvalid_o = (state_q == ST_OUT);

  always_comb begin
    case (reg_e'(paddr_i[4:2]))
      REG_SPEED:  prdata_o = {16'd0, speed_q};
      REG_SENS:   prdata_o = {16'd0, sens_q};
      REG_HOME_X: prdata_o = home_q[0];
      REG_HOME_Y: prdata_o = home_q[1];
      REG_HOME_Z: prdata_o = home_q[2];
      default:    prdata_o = '0;
    endcase
  end

  assign m_tdata_o = {up_q[2], up_q[1], up_q[0], right_z_q, 16'd0, right_x_q,
                      front_q[2], front_q[1], front_q[0], pos_q[2], pos_q[1], pos_q[0]};

  fcou_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  fcou_cordic #(.TRIG_STEPS(TRIG_STEPS)) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cord_start),
    .angle_i (cord_angle),
    .done_o  (cord_done),
    .cos_o   (cord_cos),
    .sin_o   (cord_sin)
  );

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      comp[k] = '0;
    end
    case (dir_e'(dir_q))
      DIR_FWD: begin
        for (int k = 0; k < 3; k++) comp[k] = 17'(front_q[k]);
      end
      DIR_BACK: begin
        for (int k = 0; k < 3; k++) comp[k] = -17'(front_q[k]);
      end
      DIR_LEFT: begin
        comp[0] = -17'(right_x_q);
        comp[2] = -17'(right_z_q);
      end
      DIR_RIGHT: begin
        comp[0] = 17'(right_x_q);
        comp[2] = 17'(right_z_q);
      end
      DIR_UP:   comp[1] = 17'(One14);
      DIR_DOWN: comp[1] = -17'(One14);
      default: ;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_LOOK_X: begin
        mul_a = 33'(xo_q);
        mul_b = 33'(signed'({1'b0, sens_q}));
      end
      ST_LOOK_Y: begin
        mul_a = 33'(yo_q);
        mul_b = 33'(signed'({1'b0, sens_q}));
      end
      ST_BASIS0: begin
        mul_a = 33'(cy_q);
        mul_b = 33'(cp_q);
      end
      ST_BASIS1: begin
        mul_a = 33'(sy_q);
        mul_b = 33'(cp_q);
      end
      ST_BASIS2: begin
        mul_a = -33'(cy_q);
        mul_b = 33'(sp_q);
      end
      ST_BASIS3: begin
        mul_a = -33'(sy_q);
        mul_b = 33'(sp_q);
      end
      ST_MOVE_VEL: begin
        mul_a = 33'(signed'({1'b0, speed_q}));
        mul_b = 33'(signed'({1'b0, dt_q}));
      end
      ST_MOVE_X: begin
        mul_a = signed'({1'b0, vel_q});
        mul_b = 33'(comp[0]);
      end
      ST_MOVE_Y: begin
        mul_a = signed'({1'b0, vel_q});
        mul_b = 33'(comp[1]);
      end
      ST_MOVE_Z: begin
        mul_a = signed'({1'b0, vel_q});
        mul_b = 33'(comp[2]);
      end
      default: ;
    endcase
  end

  always_comb begin
    cord_start = (state_q == ST_CORD_Y) || (state_q == ST_CORD_P);
    if (state_q == ST_CORD_Y) begin
      cord_angle = (yaw_q >= 25'(HalfTurn)) ? 26'(signed'({1'b0, yaw_q})) - 26'(FullTurn)
                                            : 26'(signed'({1'b0, yaw_q}));
    end else begin
      cord_angle = 26'(pitch_q);
    end
  end

  always_comb begin
    rnd8      = (mul_p + 66'sd128) >>> 8;
    dmove     = 34'((mul_p + 66'sd2097152) >>> 22);
    ys_step   = FullTurn << cnt_q;
    pitch_sum = 35'(pitch_q) + 35'(rnd8);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          case (kind_e'(s_tuser_i))
            KIND_MOVE: state_d = (s_tdata_i[2:0] > DIR_DOWN) ? ST_OUT : ST_MOVE_VEL;
            KIND_LOOK: state_d = ST_LOOK_X;
            default:   state_d = ST_OUT;
          endcase
        end
      end
      ST_LOOK_X:   state_d = ST_LOOK_Y;
      ST_LOOK_Y:   state_d = ST_LOOK_P;
      ST_LOOK_P:   state_d = ST_YAW_MOD;
      ST_YAW_MOD:  state_d = (cnt_q == 3'd0) ? ST_CORD_Y : ST_YAW_MOD;
      ST_CORD_Y:   state_d = ST_WAIT_Y;
      ST_WAIT_Y:   state_d = cord_done ? ST_CORD_P : ST_WAIT_Y;
      ST_CORD_P:   state_d = ST_WAIT_P;
      ST_WAIT_P:   state_d = cord_done ? ST_BASIS0 : ST_WAIT_P;
      ST_BASIS0:   state_d = ST_BASIS1;
      ST_BASIS1:   state_d = ST_BASIS2;
      ST_BASIS2:   state_d = ST_BASIS3;
      ST_BASIS3:   state_d = ST_BASIS4;
      ST_BASIS4:   state_d = ST_OUT;
      ST_MOVE_VEL: state_d = ST_MOVE_CAP;
      ST_MOVE_CAP: state_d = ST_MOVE_X;
      ST_MOVE_X:   state_d = ST_MOVE_Y;
      ST_MOVE_Y:   state_d = ST_MOVE_Z;
      ST_MOVE_Z:   state_d = ST_MOVE_END;
      ST_MOVE_END: state_d = ST_OUT;
      ST_OUT:      state_d = m_tready_i ? ST_IDLE : ST_OUT;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      dir_q <= s_tdata_i[2:0];
      dt_q  <= s_tdata_i[18:3];
      xo_q  <= s_tdata_i[42:19];
      yo_q  <= s_tdata_i[66:43];
    end
    if (state_q == ST_LOOK_Y) begin
      ys_q <= {11'd0, yaw_q} + 36'(rnd8) + YawBias;
      cnt_q <= 3'd7;
    end
    if (state_q == ST_YAW_MOD) begin
      if (ys_q >= ys_step) begin
        ys_q <= ys_q - ys_step;
      end
      cnt_q <= cnt_q - 3'd1;
    end
    if (state_q == ST_WAIT_Y && cord_done) begin
      cy_q <= cord_cos;
      sy_q <= cord_sin;
    end
    if (state_q == ST_WAIT_P && cord_done) begin
      cp_q <= cord_cos;
      sp_q <= cord_sin;
    end
    if (state_q == ST_MOVE_CAP) begin
      vel_q <= mul_p[31:0];
    end
  end

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] p,
                                                 input logic signed [33:0] d);
    logic signed [34:0] s;
    logic signed [31:0] r;
    s = 35'(p) + 35'(d);
    if (s > 35'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (s < -35'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q   <= SpeedReset;
      sens_q    <= SensReset;
      for (int k = 0; k < 3; k++) begin
        home_q[k] <= '0;
        pos_q[k]  <= '0;
      end
      yaw_q      <= YawHome;
      pitch_q    <= '0;
      front_q[0] <= '0;
      front_q[1] <= '0;
      front_q[2] <= -One14;
      right_x_q  <= One14;
      right_z_q  <= '0;
      up_q[0]    <= '0;
      up_q[1]    <= One14;
      up_q[2]    <= '0;
    end else begin
      if (cfg_wr) begin
        case (reg_e'(paddr_i[4:2]))
          REG_SPEED:  speed_q   <= pwdata_i[15:0];
          REG_SENS:   sens_q    <= pwdata_i[15:0];
          REG_HOME_X: home_q[0] <= pwdata_i;
          REG_HOME_Y: home_q[1] <= pwdata_i;
          REG_HOME_Z: home_q[2] <= pwdata_i;
          default: ;
        endcase
      end
      if (s_acc && kind_e'(s_tuser_i) == KIND_HOME) begin
        for (int k = 0; k < 3; k++) begin
          pos_q[k] <= home_q[k];
        end
        yaw_q      <= YawHome;
        pitch_q    <= '0;
        front_q[0] <= '0;
        front_q[1] <= '0;
        front_q[2] <= -One14;
        right_x_q  <= One14;
        right_z_q  <= '0;
        up_q[0]    <= '0;
        up_q[1]    <= One14;
        up_q[2]    <= '0;
      end
      if (state_q == ST_LOOK_P) begin
        if (pitch_sum > PitchLimit) begin
          pitch_q <= PitchLimit[23:0];
        end else if (pitch_sum < -PitchLimit) begin
          pitch_q <= 24'(-PitchLimit);
        end else begin
          pitch_q <= pitch_sum[23:0];
        end
      end
      if (state_q == ST_YAW_MOD && cnt_q == 3'd0) begin
        yaw_q <= (ys_q >= ys_step) ? 25'(ys_q - ys_step) : ys_q[24:0];
      end
      if (state_q == ST_BASIS1) front_q[0] <= round_q14(mul_p, 46);
      if (state_q == ST_BASIS2) front_q[2] <= round_q14(mul_p, 46);
      if (state_q == ST_BASIS3) up_q[0]    <= round_q14(mul_p, 46);
      if (state_q == ST_BASIS4) begin
        up_q[2]    <= round_q14(mul_p, 46);
        front_q[1] <= round_q14(66'(sp_q), 16);
        right_x_q  <= round_q14(-66'(sy_q), 16);
        right_z_q  <= round_q14(66'(cy_q), 16);
        up_q[1]    <= round_q14(66'(cp_q), 16);
      end
      if (state_q == ST_MOVE_Y)   pos_q[0] <= sat_add(pos_q[0], dmove);
      if (state_q == ST_MOVE_Z)   pos_q[1] <= sat_add(pos_q[1], dmove);
      if (state_q == ST_MOVE_END) pos_q[2] <= sat_add(pos_q[2], dmove);
    end
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_tready_o && m_tvalid_o))
    else $error("input ready while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_tready_o)
    else $error("item accepted twice without a result");

  a_pitch_cordic_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WAIT_Y && cord_done) |=> (state_q == ST_CORD_P))
    else $error("pitch pass did not follow yaw pass");

endmodule
`default_nettype wire
